/* design/sfls_pkg.sv */
// Shared types and constants for the substring first/last search block.
// No dependencies.
`timescale 1ns / 1ps

package sfls_pkg;

  localparam int POS_BITS = 16;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic pat_clear;
    logic pat_shift;
    logic txt_shift;
  } cell_ctrl_t;

endpackage

/* design/sfls_req_if.sv */
// Request channel: command and character, valid/ready handshake.
// Depends on nothing.
`timescale 1ns / 1ps

interface sfls_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] ch;

  modport source (output valid, output command, output ch, input ready);
  modport sink (input valid, input command, input ch, output ready);
endinterface

/* design/sfls_rsp_if.sv */
// Result channel: first/last match report, valid/ready handshake.
// Depends on sfls_pkg for the position width.
`timescale 1ns / 1ps

interface sfls_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          first_found;
  logic [sfls_pkg::POS_BITS-1:0] first_pos;
  logic                          last_found;
  logic [sfls_pkg::POS_BITS-1:0] last_pos;
  logic                          overflow;

  modport source (output valid, output first_found, output first_pos, output last_found,
                  output last_pos, output overflow, input ready);
  modport sink (input valid, input first_found, input first_pos, input last_found,
                input last_pos, input overflow, output ready);
endinterface

/* design/sfls_cell.sv */
// One compare cell: holds a pattern char (reversed order), an active bit and a
// window char, shifts both to its neighbor, and registers a per-cell hit bit.
// Depends on sfls_pkg.
`timescale 1ns / 1ps

module sfls_cell #(
  parameter int CHAR_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sfls_pkg::cell_ctrl_t   ctrl,
  input  logic [CHAR_BITS-1:0]   pat_in,
  input  logic                   act_in,
  input  logic [CHAR_BITS-1:0]   txt_in,
  output logic [CHAR_BITS-1:0]   pat_out,
  output logic                   act_out,
  output logic [CHAR_BITS-1:0]   txt_out,
  output logic                   hit
);

  logic [CHAR_BITS-1:0] pat;
  logic                 act;
  logic [CHAR_BITS-1:0] txt;

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
    end else if (ctrl.pat_clear) begin
      act <= 1'b0;
    end else if (ctrl.pat_shift) begin
      act <= act_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pat_shift) begin
      pat <= pat_in;
    end
    if (ctrl.txt_shift) begin
      txt <= txt_in;
      hit <= !act || (pat == txt_in);
    end
  end

  assign pat_out = pat;
  assign act_out = act;
  assign txt_out = txt;

endmodule

/* design/substring_first_last_search.sv */
// Substring first/last search in two register stages: compare cells, hit tracker.
// Throughput: one transaction per cycle unless an end of text waits on an unread result;
// each cell compares its window char on the shift. Reset (synchronous): empties pattern
// and text state, drops all valids; no clearing pass.
// Depends on sfls_pkg, sfls_req_if, sfls_rsp_if and sfls_cell.
`timescale 1ns / 1ps

module substring_first_last_search #(
  parameter int PATTERN_MAX = 16,
  parameter int INDEX_BITS  = 16,
  parameter int CHAR_BITS   = 8
) (
  input logic       clk,
  input logic       rst,
  sfls_req_if.sink  req,
  sfls_rsp_if.source rsp
);

  localparam int LEN_BITS = $clog2(PATTERN_MAX + 1);
  localparam int PB       = sfls_pkg::POS_BITS;
  localparam logic [INDEX_BITS-1:0] COUNT_MAX = '1;

  sfls_pkg::cmd_t       cmd;
  logic                 accept;
  logic [CHAR_BITS-1:0] ch_ext;
  sfls_pkg::cell_ctrl_t ctrl;

  logic [CHAR_BITS-1:0] pat_q [PATTERN_MAX];
  logic [CHAR_BITS-1:0] txt_q [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] act_q;
  logic [PATTERN_MAX-1:0] hit_q;

  logic [LEN_BITS-1:0]   len;
  logic [INDEX_BITS-1:0] count;
  logic [INDEX_BITS-1:0] count_next;
  logic                  ovf;
  logic                  restart;

  logic                  s2_valid;
  sfls_pkg::cmd_t        s2_op;
  logic                  s2_cond;
  logic [PB-1:0]         s2_start;
  logic [PB-1:0]         s2_count;
  logic                  s2_ovf;
  logic                  s2_lenzero;
  logic                  s2_go;
  logic                  match;

  logic                  first_v;
  logic [PB-1:0]         first_p;
  logic                  last_v;
  logic [PB-1:0]         last_p;

  logic                  out_valid;
  logic                  out_first_found;
  logic [PB-1:0]         out_first_pos;
  logic                  out_last_found;
  logic [PB-1:0]         out_last_pos;
  logic                  out_overflow;

  assign cmd    = sfls_pkg::cmd_t'(req.command);
  assign ch_ext = CHAR_BITS'(req.ch);
  assign s2_go  = s2_valid && ((s2_op != sfls_pkg::CMD_END) || !out_valid || rsp.ready);
  assign req.ready = !s2_valid || s2_go;
  assign accept = req.valid && req.ready;
  assign restart = accept && ((cmd == sfls_pkg::CMD_CLEAR) || (cmd == sfls_pkg::CMD_APPEND));

  assign ctrl.pat_clear = accept && (cmd == sfls_pkg::CMD_CLEAR);
  assign ctrl.pat_shift = accept && (cmd == sfls_pkg::CMD_APPEND) && !act_q[PATTERN_MAX-1];
  assign ctrl.txt_shift = accept && (cmd == sfls_pkg::CMD_TEXT);

  // Cell j holds pattern[len-1-j] against window entry j (newest first).
  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    sfls_cell #(.CHAR_BITS(CHAR_BITS)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .pat_in  ((j == 0) ? ch_ext : pat_q[(j == 0) ? 0 : j - 1]),
      .act_in  ((j == 0) ? 1'b1 : act_q[(j == 0) ? 0 : j - 1]),
      .txt_in  ((j == 0) ? ch_ext : txt_q[(j == 0) ? 0 : j - 1]),
      .pat_out (pat_q[j]),
      .act_out (act_q[j]),
      .txt_out (txt_q[j]),
      .hit     (hit_q[j])
    );
  end

  assign count_next = (count == COUNT_MAX) ? count : count + 1'b1;
  assign match      = &hit_q;

  // Stage 1: length, text counter, transaction handoff to the tracker.
  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      count    <= '0;
      ovf      <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (accept) begin
        s2_valid <= 1'b1;
      end else if (s2_go) begin
        s2_valid <= 1'b0;
      end
      if (ctrl.pat_clear) begin
        len <= '0;
      end else if (ctrl.pat_shift) begin
        len <= len + 1'b1;
      end
      if (accept) begin
        unique case (cmd)
          sfls_pkg::CMD_TEXT: begin
            count <= count_next;
            if (count == COUNT_MAX) begin
              ovf <= 1'b1;
            end
          end
          default: begin
            count <= '0;
            ovf   <= 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_op      <= cmd;
      s2_cond    <= (len != '0) && (count_next >= INDEX_BITS'(len));
      s2_start   <= PB'(count_next - INDEX_BITS'(len));
      s2_count   <= PB'(count);
      s2_ovf     <= ovf;
      s2_lenzero <= (len == '0);
    end
  end

  // Stage 2: hit tracker and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_v   <= 1'b0;
      last_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_go && (s2_op == sfls_pkg::CMD_END)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (s2_go) begin
        unique case (s2_op)
          sfls_pkg::CMD_TEXT: begin
            if (s2_cond && match) begin
              if (!first_v) begin
                first_v <= 1'b1;
                first_p <= s2_start;
              end
              last_v <= 1'b1;
              last_p <= s2_start;
            end
          end
          default: begin
            first_v <= 1'b0;
            last_v  <= 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && (s2_op == sfls_pkg::CMD_END)) begin
      out_overflow <= s2_ovf;
      if (s2_lenzero) begin
        out_first_found <= 1'b1;
        out_first_pos   <= '0;
        out_last_found  <= 1'b1;
        out_last_pos    <= s2_count;
      end else begin
        out_first_found <= first_v;
        out_first_pos   <= first_v ? first_p : '0;
        out_last_found  <= last_v;
        out_last_pos    <= last_v ? last_p : '0;
      end
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.first_found = out_first_found;
  assign rsp.first_pos   = out_first_pos;
  assign rsp.last_found  = out_last_found;
  assign rsp.last_pos    = out_last_pos;
  assign rsp.overflow    = out_overflow;

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    restart |=> (count == '0) && !ovf)
    else $error("text state not cleared on pattern change");

  a_len_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(act_q) == int'(len))
    else $error("pattern length disagrees with active cells");

  a_ovf_saturated: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (count == COUNT_MAX))
    else $error("overflow flag without saturated count");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s2_valid && (s2_op == sfls_pkg::CMD_END)))
    else $error("result raised without end of text");

endmodule

/* test/tb_top.sv */
// Testbench for substring_first_last_search: a scoreboard class predicts each report,
// tasks drive requests with random idling; an always block adds result back-pressure.
// Depends on sfls_pkg, sfls_req_if, sfls_rsp_if and the search block itself.
`timescale 1ns / 1ps

package sfls_tb_pkg;

  localparam int PAT_DEPTH = 16;

  typedef struct packed {
    logic                          first_found;
    logic [sfls_pkg::POS_BITS-1:0] first_pos;
    logic                          last_found;
    logic [sfls_pkg::POS_BITS-1:0] last_pos;
    logic                          overflow;
  } search_report_t;

  class search_scoreboard;
    logic [7:0]                    pat_chars[PAT_DEPTH];
    int unsigned                   pat_len;
    logic [7:0]                    window[PAT_DEPTH];
    logic [sfls_pkg::POS_BITS-1:0] txt_count;
    bit                            first_hit;
    logic [sfls_pkg::POS_BITS-1:0] first_at;
    bit                            last_hit;
    logic [sfls_pkg::POS_BITS-1:0] last_at;
    bit                            count_sat;
    search_report_t                reports_due[$];
    int unsigned                   fails;
    int unsigned                   reports_seen;
    int unsigned                   match_reports;
    int unsigned                   overflow_reports;

    function new();
      foreach (pat_chars[i]) pat_chars[i] = '0;
      pat_len = 0;
      fails = 0;
      reports_seen = 0;
      match_reports = 0;
      overflow_reports = 0;
      restart_text();
    endfunction

    function void restart_text();
      foreach (window[i]) window[i] = '0;
      txt_count = '0;
      first_hit = 0;
      first_at = '0;
      last_hit = 0;
      last_at = '0;
      count_sat = 0;
    endfunction

    // Called for every accepted request transaction.
    function void note_request(sfls_pkg::cmd_t cmd, logic [7:0] c);
      bit             hit;
      search_report_t rep;
      case (cmd)
        sfls_pkg::CMD_CLEAR: begin
          pat_len = 0;
          restart_text();
        end
        sfls_pkg::CMD_APPEND: begin
          if (pat_len < PAT_DEPTH) begin
            pat_chars[pat_len] = c;
            pat_len++;
          end
          restart_text();
        end
        sfls_pkg::CMD_TEXT: begin
          for (int i = PAT_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
          window[0] = c;
          if (txt_count == '1) count_sat = 1;
          else txt_count++;
          if (pat_len != 0 && txt_count >= pat_len) begin
            hit = 1;
            for (int i = 0; i < pat_len; i++) begin
              if (pat_chars[i] != window[pat_len-1-i]) hit = 0;
            end
            if (hit) begin
              if (!first_hit) begin
                first_hit = 1;
                first_at = txt_count - pat_len;
              end
              last_hit = 1;
              last_at = txt_count - pat_len;
            end
          end
        end
        default: begin
          if (pat_len == 0) begin
            rep.first_found = 1'b1;
            rep.first_pos   = '0;
            rep.last_found  = 1'b1;
            rep.last_pos    = txt_count;
          end else begin
            rep.first_found = first_hit;
            rep.first_pos   = first_at;
            rep.last_found  = last_hit;
            rep.last_pos    = last_at;
          end
          rep.overflow = count_sat;
          reports_due.push_back(rep);
          restart_text();
        end
      endcase
    endfunction

    function void compare_field(string name, logic [sfls_pkg::POS_BITS-1:0] exp,
                                logic [sfls_pkg::POS_BITS-1:0] act);
      if (act !== exp) begin
        $display("%0t: mismatch %s expected %h actual %h", $time, name, exp, act);
        fails++;
      end
    endfunction

    // Called for every accepted result transaction.
    function void check_report(search_report_t got);
      search_report_t exp;
      if (reports_due.size() == 0) begin
        $display("%0t: unexpected report, expected none actual %h", $time, got);
        fails++;
        return;
      end
      exp = reports_due.pop_front();
      reports_seen++;
      if (exp.last_found) match_reports++;
      if (exp.overflow) overflow_reports++;
      compare_field("first_found", exp.first_found, got.first_found);
      compare_field("first_pos", exp.first_pos, got.first_pos);
      compare_field("last_found", exp.last_found, got.last_found);
      compare_field("last_pos", exp.last_pos, got.last_pos);
      compare_field("overflow", exp.overflow, got.overflow);
    endfunction
  endclass

endpackage

module tb_top;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 20;

  logic clk = 1'b0;
  logic rst;

  sfls_req_if req_ch ();
  sfls_rsp_if rsp_ch ();

  substring_first_last_search u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  sfls_tb_pkg::search_scoreboard sb = new();

  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned items_accepted = 0;
  int unsigned stall_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: random ready, with an occasional long hold-off.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        sb.note_request(sfls_pkg::cmd_t'(req_ch.command), req_ch.ch);
        items_accepted++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        sb.check_report(sfls_tb_pkg::search_report_t'{rsp_ch.first_found, rsp_ch.first_pos,
                                                      rsp_ch.last_found, rsp_ch.last_pos,
                                                      rsp_ch.overflow});
      end
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  // Starts and ends at a falling edge; valid stays high for a back-to-back transaction.
  task automatic send_req(sfls_pkg::cmd_t cmd, logic [7:0] c);
    while ($urandom_range(99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.command <= cmd;
    req_ch.ch      <= c;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.reports_due.size() != 0) @(negedge clk);
  endtask

  // Receiver holds off while a burst of empty texts fills the block.
  task automatic hold_and_flood();
    hold_req <= hold_req + 1;
    repeat (40) send_req(sfls_pkg::CMD_END, 8'($urandom));
  endtask

  task automatic random_phase(int unsigned n_items, bit with_hold);
    logic [7:0]  pat[$];
    logic [7:0]  base;
    int unsigned plen;
    int unsigned tlen;
    int unsigned done;
    done = 0;
    while (done < n_items) begin
      if (with_hold && done >= n_items / 2) begin
        hold_and_flood();
        with_hold = 0;
      end
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 4)) begin
          send_req(sfls_pkg::cmd_t'($urandom_range(3)), 8'($urandom));
          done++;
        end
      end else begin
        base = 8'($urandom);
        plen = ($urandom_range(9) == 0) ? $urandom_range(6, 17) : $urandom_range(0, 4);
        pat.delete();
        send_req(sfls_pkg::CMD_CLEAR, 8'($urandom));
        done++;
        repeat (plen) begin
          pat.push_back(base ^ 8'($urandom_range(3)));
          send_req(sfls_pkg::CMD_APPEND, pat[$]);
          done++;
        end
        repeat ($urandom_range(1, 3)) begin
          tlen = $urandom_range(0, 30);
          for (int k = 0; k < tlen; k++) begin
            if ($urandom_range(3) == 0) begin
              foreach (pat[j]) begin
                send_req(sfls_pkg::CMD_TEXT, pat[j]);
                done++;
              end
            end else begin
              send_req(sfls_pkg::CMD_TEXT, base ^ 8'($urandom_range(3)));
              done++;
            end
          end
          send_req(sfls_pkg::CMD_END, 8'($urandom));
          done++;
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.command = sfls_pkg::CMD_CLEAR;
    req_ch.ch = '0;
    rsp_ch.ready = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_gap_pct = 7;
    recv_gap_pct = 61;
    // empty pattern, empty text, then empty pattern over two chars
    send_req(sfls_pkg::CMD_END, 8'h00);
    send_req(sfls_pkg::CMD_TEXT, 8'h00);
    send_req(sfls_pkg::CMD_TEXT, 8'hFF);
    send_req(sfls_pkg::CMD_END, 8'hFF);
    // pattern longer than text
    send_req(sfls_pkg::CMD_APPEND, 8'h61);
    send_req(sfls_pkg::CMD_APPEND, 8'h62);
    send_req(sfls_pkg::CMD_TEXT, 8'h61);
    send_req(sfls_pkg::CMD_END, 8'h00);
    // two matches
    send_req(sfls_pkg::CMD_TEXT, 8'h61);
    send_req(sfls_pkg::CMD_TEXT, 8'h62);
    send_req(sfls_pkg::CMD_TEXT, 8'h61);
    send_req(sfls_pkg::CMD_TEXT, 8'h62);
    send_req(sfls_pkg::CMD_END, 8'h00);
    // pattern change mid-text restarts it
    send_req(sfls_pkg::CMD_TEXT, 8'h61);
    send_req(sfls_pkg::CMD_APPEND, 8'h63);
    send_req(sfls_pkg::CMD_TEXT, 8'h61);
    send_req(sfls_pkg::CMD_TEXT, 8'h62);
    send_req(sfls_pkg::CMD_TEXT, 8'h63);
    send_req(sfls_pkg::CMD_END, 8'h00);
    send_req(sfls_pkg::CMD_CLEAR, 8'hFF);
    send_req(sfls_pkg::CMD_TEXT, 8'hFF);
    send_req(sfls_pkg::CMD_END, 8'h00);
    // full pattern; the extra append is dropped
    repeat (16) send_req(sfls_pkg::CMD_APPEND, 8'h00);
    send_req(sfls_pkg::CMD_APPEND, 8'hFF);
    repeat (17) send_req(sfls_pkg::CMD_TEXT, 8'h00);
    send_req(sfls_pkg::CMD_END, 8'h00);
    drain();

    random_phase(370, 1'b1);
    drain();
    send_gap_pct = 61;
    recv_gap_pct = 7;
    random_phase(370, 1'b0);
    drain();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    random_phase(370, 1'b0);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run: %0d request transactions, %0d reports checked", items_accepted,
             sb.reports_seen);
    $display("run: %0d reports with a match, %0d with counter overflow", sb.match_reports,
             sb.overflow_reports);
    if (sb.fails == 0 && sb.reports_due.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
design/sfls_pkg.sv
design/sfls_req_if.sv
design/sfls_rsp_if.sv
design/sfls_cell.sv
design/substring_first_last_search.sv
test/tb_top.sv
